### rtl/core/jpd_pkg.sv
package jpd_pkg;

    // joint store
    localparam int NUM_JOINTS = 16;
    localparam int JOINT_AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // field widths
    localparam int JOINT_W = 4;
    localparam int Q_W     = 32;
    localparam int MAG_W   = 31;
    localparam int FRAC_W  = 16;

    // shared multiplier: 33 bit signed difference by 32 bit signed operand
    localparam int MUL_A_W = Q_W + 1;
    localparam int MUL_B_W = Q_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = TERM_W + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_STOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_STOP   = 2'd2;

    // configuration reset values
    localparam logic [MAG_W-1:0] INV_PERIOD_RST = 31'd65536000;
    localparam logic [Q_W-1:0]   STOP_CODE_RST  = 32'h7fff_ffff;

    typedef struct packed {
        logic [JOINT_W-1:0]  joint;
        logic signed [Q_W-1:0] cmd_position;
        logic signed [Q_W-1:0] cmd_velocity;
        logic [MAG_W-1:0]    pos_gain;
        logic [MAG_W-1:0]    vel_gain;
        logic signed [Q_W-1:0] ff_torque;
        logic signed [Q_W-1:0] measured_position;
        logic signed [Q_W-1:0] pos_lower;
        logic signed [Q_W-1:0] pos_upper;
        logic [MAG_W-1:0]    vel_limit;
        logic [MAG_W-1:0]    effort_limit;
    } jpd_in_t;

    typedef struct packed {
        logic [JOINT_W-1:0]  out_joint;
        logic signed [Q_W-1:0] torque;
        logic signed [Q_W-1:0] est_velocity;
    } jpd_out_t;

endpackage

### rtl/core/jpd_in_if.sv
interface jpd_in_if;
    logic            valid;
    logic            ready;
    jpd_pkg::jpd_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/jpd_out_if.sv
interface jpd_out_if;
    logic             valid;
    logic             ready;
    jpd_pkg::jpd_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/jpd_ram.sv
module jpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/jpd_mul.sv
// shared signed multiplier, product registered
module jpd_mul (
    input  logic                               clk,
    input  logic signed [jpd_pkg::MUL_A_W-1:0] a,
    input  logic signed [jpd_pkg::MUL_B_W-1:0] b,
    output logic signed [jpd_pkg::PROD_W-1:0]  prod_reg
);

    logic signed [jpd_pkg::PROD_W-1:0] prod_next;

    assign prod_next = jpd_pkg::PROD_W'(a) * jpd_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

### rtl/core/joint_pd_torque_controller.sv
// Joint PD torque controller, Q16.16 throughout. Each step word serves one joint:
// commands are clamped to their limits, a command equal to its stop code zeroes
// its gain, velocity is estimated as (measured - last measured) * inverse_period,
// and torque = kp*(pos error) + kd*(vel error) + ff is saturated to +/-effort_limit.
// A joint's first step after reset gives zero velocity. A step word is taken only
// while the sequencer is idle. The result word is loaded after acceptance through
// the RD, POS, KD and SUM states: the single shared multiplier forms the velocity,
// position and damping products in turn, then the final sum is saturated and loaded.
// The sequencer is idle again after that load, so the next word is taken only once
// the previous result word is loaded. The sum cycle holds, with the damping product
// kept on the multiplier, while an earlier result word waits unread. The last
// positions live in a small synchronous RAM (one read per step, one write for a
// joint in range); seen flags are flip-flops cleared by reset, so no clearing pass
// is needed. The result register lets a new step word be taken while a result waits.
module joint_pd_torque_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    jpd_in_if.sink                          step,
    jpd_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [jpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jpd_pkg::Q_W-1:0]         cfg_data
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1; // stored position available, velocity product
    localparam logic [2:0] ST_POS  = 3'd2; // saturate velocity, position product
    localparam logic [2:0] ST_KD   = 3'd3; // damping product
    localparam logic [2:0] ST_SUM  = 3'd4; // final sum and load of result register

    localparam int Q_W     = jpd_pkg::Q_W;
    localparam int MAG_W   = jpd_pkg::MAG_W;
    localparam int TERM_W  = jpd_pkg::TERM_W;
    localparam int SUM_W   = jpd_pkg::SUM_W;
    localparam int FRAC_W  = jpd_pkg::FRAC_W;
    localparam int PROD_W  = jpd_pkg::PROD_W;
    localparam int MUL_A_W = jpd_pkg::MUL_A_W;
    localparam int MUL_B_W = jpd_pkg::MUL_B_W;
    localparam int JOINT_AW = jpd_pkg::JOINT_AW;

    // configuration
    logic [MAG_W-1:0]      inv_period_reg;
    logic signed [Q_W-1:0] pos_stop_reg;
    logic signed [Q_W-1:0] vel_stop_reg;

    // sequencer and flags
    logic [2:0] state_reg, state_next;
    logic [jpd_pkg::NUM_JOINTS-1:0] seen_reg, seen_next;
    logic out_valid_reg, out_valid_next;

    // per-step operands, captured at acceptance
    logic [jpd_pkg::JOINT_W-1:0] joint_reg;
    logic                        in_range_reg;
    logic                        seen_hit_reg;
    logic signed [Q_W-1:0]       pos_c_reg;
    logic signed [Q_W-1:0]       vel_c_reg;
    logic signed [Q_W-1:0]       ff_c_reg;
    logic signed [Q_W-1:0]       meas_reg;
    logic [MAG_W-1:0]            kp_reg;
    logic [MAG_W-1:0]            kd_reg;
    logic [MAG_W-1:0]            elim_reg;

    // intermediate results
    logic signed [Q_W-1:0]    vel_reg;
    logic signed [TERM_W-1:0] term_p_reg;
    jpd_pkg::jpd_out_t        out_reg;

    // input stage logic
    jpd_pkg::jpd_in_t      din;
    logic                  take;
    logic [JOINT_AW-1:0]   jaddr_in;
    logic                  in_range_in;
    logic signed [Q_W-1:0] pos_lo_c;
    logic signed [Q_W-1:0] pos_c_in;
    logic signed [Q_W-1:0] vlim_s;
    logic signed [Q_W-1:0] elim_s;
    logic signed [Q_W-1:0] vel_c_in;
    logic signed [Q_W-1:0] ff_c_in;

    // memory and multiplier
    logic [JOINT_AW-1:0]         jaddr_reg;
    logic [JOINT_AW-1:0]         ram_raddr;
    logic                        ram_we;
    logic signed [Q_W-1:0]       ram_rdata;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [TERM_W-1:0]    prod_floor;

    // velocity saturation and final sum
    logic                        vel_fits;
    logic signed [Q_W-1:0]       vel_sat;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     elim_w;
    logic signed [Q_W-1:0]       torque_sat;
    logic                        out_free;

    assign din         = step.data;
    assign step.ready  = (state_reg == ST_IDLE);
    assign take        = step.valid && step.ready;
    assign jaddr_in    = JOINT_AW'(din.joint);
    assign in_range_in = (32'(din.joint) < 32'(jpd_pkg::NUM_JOINTS));
    assign jaddr_reg   = JOINT_AW'(joint_reg);

    // clamp position: raise to lower limit first, so the upper limit wins when crossed
    assign pos_lo_c = (din.cmd_position < din.pos_lower) ? din.pos_lower : din.cmd_position;
    assign pos_c_in = (pos_lo_c > din.pos_upper) ? din.pos_upper : pos_lo_c;

    // symmetric clamps of velocity command and feed-forward
    assign vlim_s   = $signed({1'b0, din.vel_limit});
    assign elim_s   = $signed({1'b0, din.effort_limit});
    assign vel_c_in = (din.cmd_velocity < -vlim_s) ? -vlim_s :
                      (din.cmd_velocity > vlim_s) ? vlim_s : din.cmd_velocity;
    assign ff_c_in  = (din.ff_torque < -elim_s) ? -elim_s :
                      (din.ff_torque > elim_s) ? elim_s : din.ff_torque;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_period_reg <= jpd_pkg::INV_PERIOD_RST;
            pos_stop_reg   <= jpd_pkg::STOP_CODE_RST;
            vel_stop_reg   <= jpd_pkg::STOP_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jpd_pkg::CFG_INV_PERIOD: inv_period_reg <= cfg_data[MAG_W-1:0];
                jpd_pkg::CFG_POS_STOP:   pos_stop_reg   <= cfg_data;
                jpd_pkg::CFG_VEL_STOP:   vel_stop_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // operand capture; stop codes compare the raw commands
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            joint_reg    <= din.joint;
            in_range_reg <= in_range_in;
            seen_hit_reg <= in_range_in && seen_reg[jaddr_in];
            pos_c_reg    <= pos_c_in;
            vel_c_reg    <= vel_c_in;
            ff_c_reg     <= ff_c_in;
            meas_reg     <= din.measured_position;
            kp_reg       <= (din.cmd_position == pos_stop_reg) ? '0 : din.pos_gain;
            kd_reg       <= (din.cmd_velocity == vel_stop_reg) ? '0 : din.vel_gain;
            elim_reg     <= din.effort_limit;
        end
    end

    // last position store: read on acceptance, written back once the old value is used
    assign ram_raddr = (state_reg == ST_IDLE) ? jaddr_in : jaddr_reg;
    assign ram_we    = (state_reg == ST_RD) && in_range_reg;

    jpd_ram #(
        .WIDTH (Q_W),
        .DEPTH (jpd_pkg::NUM_JOINTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (jaddr_reg),
        .wdata (meas_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand selection for the shared multiplier, one product per sequencer cycle;
    // damping operands stay on while the sum cycle waits for the result register
    always_comb
    begin
        unique case (state_reg) inside
            ST_RD:
            begin
                mul_a = MUL_A_W'(meas_reg) - MUL_A_W'(ram_rdata);
                mul_b = $signed({1'b0, inv_period_reg});
            end
            ST_KD, ST_SUM:
            begin
                mul_a = MUL_A_W'(vel_c_reg) - MUL_A_W'(vel_reg);
                mul_b = $signed({1'b0, kd_reg});
            end
            default:
            begin
                mul_a = MUL_A_W'(pos_c_reg) - MUL_A_W'(meas_reg);
                mul_b = $signed({1'b0, kp_reg});
            end
        endcase
    end

    jpd_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // arithmetic shift gives rounding toward minus infinity
    assign prod_floor = prod[PROD_W-1:FRAC_W];

    // velocity saturation to 32 bits
    assign vel_fits = (prod_floor[TERM_W-1:Q_W-1] == '0) || (prod_floor[TERM_W-1:Q_W-1] == '1);
    assign vel_sat  = vel_fits ? prod_floor[Q_W-1:0] :
                      (prod_floor[TERM_W-1] ? $signed({1'b1, {(Q_W-1){1'b0}}})
                                            : $signed({1'b0, {(Q_W-1){1'b1}}}));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POS)
        begin
            vel_reg <= seen_hit_reg ? vel_sat : '0;
        end
        if (state_reg == ST_KD)
        begin
            term_p_reg <= prod_floor;
        end
    end

    // final sum and torque saturation
    assign sum        = SUM_W'(term_p_reg) + SUM_W'(prod_floor) + SUM_W'(ff_c_reg);
    assign elim_w     = $signed({{(SUM_W-MAG_W){1'b0}}, elim_reg});
    assign torque_sat = (sum > elim_w) ? Q_W'(elim_w) :
                        (sum < -elim_w) ? Q_W'(-elim_w) : Q_W'(sum);
    assign out_free   = !out_valid_reg || result.ready;

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SUM) && out_free)
        begin
            out_reg.out_joint    <= joint_reg;
            out_reg.torque       <= torque_sat;
            out_reg.est_velocity <= vel_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // sequencer, seen flags and result valid
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (in_range_reg)
                begin
                    seen_next[jaddr_reg] = 1'b1;
                end
                state_next = ST_POS;
            end
            ST_POS:
            begin
                state_next = ST_KD;
            end
            ST_KD:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
